>>> src/tdpt_pkg.sv
// Types, step addresses and microcode program of the trial-division prime tester.
package tdpt_pkg;

    localparam int UPC_BITS = 4;

    // The only even prime; trial division starts at the next odd number.
    localparam int SMALLEST_PRIME = 2;
    localparam int FIRST_ODD_DIVISOR = 3;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_LOWER_BOUND = 2'd0;
    localparam logic [1:0] REG_UPPER_BOUND = 2'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_NEXT_DIVISOR,
        OP_CLR_PRIME,
        OP_SET_PRIME,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_START,
        CND_BELOW_TWO,
        CND_IS_TWO,
        CND_EVEN,
        CND_SQ_ABOVE_N,
        CND_COUNT_NZ,
        CND_REM_ZERO
    } t_cond;

    typedef struct packed {
        t_op                 op;
        t_cond               cond;
        logic [UPC_BITS-1:0] target;
    } t_uword;

    localparam logic [UPC_BITS-1:0] UA_IDLE      = 4'd0;
    localparam logic [UPC_BITS-1:0] UA_LT2       = 4'd1;
    localparam logic [UPC_BITS-1:0] UA_EQ2       = 4'd2;
    localparam logic [UPC_BITS-1:0] UA_EVEN      = 4'd3;
    localparam logic [UPC_BITS-1:0] UA_LOOP      = 4'd4;
    localparam logic [UPC_BITS-1:0] UA_DIV       = 4'd5;
    localparam logic [UPC_BITS-1:0] UA_CHECK     = 4'd6;
    localparam logic [UPC_BITS-1:0] UA_BACK      = 4'd7;
    localparam logic [UPC_BITS-1:0] UA_COMPOSITE = 4'd8;
    localparam logic [UPC_BITS-1:0] UA_PRIME     = 4'd9;
    localparam logic [UPC_BITS-1:0] UA_EMIT      = 4'd10;

    // Control store: the next step is the target when the condition holds,
    // otherwise the following address.
    function automatic t_uword uc_rom(input logic [UPC_BITS-1:0] addr);
        t_uword w;
        w = '{op: OP_NONE, cond: CND_ALWAYS, target: UA_IDLE};
        case (addr)
            UA_IDLE:      w = '{op: OP_LOAD,         cond: CND_NO_START,   target: UA_IDLE};
            UA_LT2:       w = '{op: OP_NONE,         cond: CND_BELOW_TWO,  target: UA_COMPOSITE};
            UA_EQ2:       w = '{op: OP_NONE,         cond: CND_IS_TWO,     target: UA_PRIME};
            UA_EVEN:      w = '{op: OP_NONE,         cond: CND_EVEN,       target: UA_COMPOSITE};
            UA_LOOP:      w = '{op: OP_DIV_INIT,     cond: CND_SQ_ABOVE_N, target: UA_PRIME};
            UA_DIV:       w = '{op: OP_DIV_STEP,     cond: CND_COUNT_NZ,   target: UA_DIV};
            UA_CHECK:     w = '{op: OP_NEXT_DIVISOR, cond: CND_REM_ZERO,   target: UA_COMPOSITE};
            UA_BACK:      w = '{op: OP_NONE,         cond: CND_ALWAYS,     target: UA_LOOP};
            UA_COMPOSITE: w = '{op: OP_CLR_PRIME,    cond: CND_ALWAYS,     target: UA_EMIT};
            UA_PRIME:     w = '{op: OP_SET_PRIME,    cond: CND_NEVER,      target: UA_IDLE};
            UA_EMIT:      w = '{op: OP_EMIT,         cond: CND_ALWAYS,     target: UA_IDLE};
            default:      w = '{op: OP_NONE,         cond: CND_ALWAYS,     target: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> src/trial_division_prime_test_core.sv
// Trial-division prime tester: one candidate in, one result out, under a microcoded sequencer.
//
// A candidate is transferred on i_candidate at a rising edge where start is high and
// busy is low. When the sequencer ends, one result is presented for exactly one cycle with
// o_strobe high: o_number echoes the candidate, o_within_range compares it with the
// configured bounds and o_prime_flag says whether it is prime. The receiver cannot
// stall the block, so every result must be taken in its strobe cycle.
// Flow: 0 and 1 are reported not prime, 2 prime and other even numbers composite,
// with no trial division. An odd number runs one pass per odd trial divisor d from
// 3 while d*d <= n, until a divisor leaves a zero remainder; each pass runs the
// bit-serial remainder unit over VALUE_BITS dividend bits (clamped to 16 bits).
// One item is in flight at a time; busy is high from acceptance until the strobe.
// The bounds are written over the configuration transfer channel (index 0 lower,
// 1 upper, others ignored), which is always ready; write them only while idle.
// Synchronous active-low reset sets lower bound 1, upper bound all ones, and idle.
module trial_division_prime_test_core #(
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_candidate,
    output logic        o_strobe,
    output logic [15:0] o_number,
    output logic        o_within_range,
    output logic        o_prime_flag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NB = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int DW = NB / 2 + 2;
    localparam int SW = NB + 2;
    localparam int CW = $clog2(NB);

    logic [tdpt_pkg::UPC_BITS-1:0] r_pc, n_pc;
    tdpt_pkg::t_uword uw;
    logic cond_true;

    logic [NB-1:0] r_n;
    logic [NB-1:0] r_lower;
    logic [NB-1:0] r_upper;
    logic [DW-1:0] r_d;
    logic [SW-1:0] r_sq;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_prime;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          fits;

    assign uw = tdpt_pkg::uc_rom(r_pc);
    assign busy = (r_pc != tdpt_pkg::UA_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        case (uw.cond)
            tdpt_pkg::CND_NEVER:      cond_true = 1'b0;
            tdpt_pkg::CND_ALWAYS:     cond_true = 1'b1;
            tdpt_pkg::CND_NO_START:   cond_true = !start;
            tdpt_pkg::CND_BELOW_TWO:  cond_true = ~|r_n[NB-1:1];
            tdpt_pkg::CND_IS_TWO:     cond_true = (r_n == NB'(tdpt_pkg::SMALLEST_PRIME));
            tdpt_pkg::CND_EVEN:       cond_true = !r_n[0];
            tdpt_pkg::CND_SQ_ABOVE_N: cond_true = (r_sq > SW'(r_n));
            tdpt_pkg::CND_COUNT_NZ:   cond_true = (r_cnt != '0);
            tdpt_pkg::CND_REM_ZERO:   cond_true = (r_rem == '0);
            default:                  cond_true = 1'b0;
        endcase
        n_pc = cond_true ? uw.target : r_pc + tdpt_pkg::UPC_BITS'(1);
    end

    // One restoring step: bring in the next dividend bit and subtract if it fits.
    assign shifted = {r_rem, r_n[r_cnt]};
    assign diff    = shifted - {1'b0, r_d};
    assign fits    = (shifted >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= tdpt_pkg::UA_IDLE;
            o_strobe <= 1'b0;
            r_lower  <= NB'(1);
            r_upper  <= '1;
        end else begin
            r_pc     <= n_pc;
            o_strobe <= (uw.op == tdpt_pkg::OP_EMIT);
            if (i_cfg_valid) begin
                if (i_cfg_index == tdpt_pkg::REG_LOWER_BOUND) begin
                    r_lower <= i_cfg_data[NB-1:0];
                end else if (i_cfg_index == tdpt_pkg::REG_UPPER_BOUND) begin
                    r_upper <= i_cfg_data[NB-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (uw.op)
            tdpt_pkg::OP_LOAD: begin
                r_n  <= i_candidate[NB-1:0];
                r_d  <= DW'(tdpt_pkg::FIRST_ODD_DIVISOR);
                r_sq <= SW'(tdpt_pkg::FIRST_ODD_DIVISOR * tdpt_pkg::FIRST_ODD_DIVISOR);
            end
            tdpt_pkg::OP_DIV_INIT: begin
                r_rem <= '0;
                r_cnt <= CW'(NB - 1);
            end
            tdpt_pkg::OP_DIV_STEP: begin
                r_rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
                r_cnt <= r_cnt - CW'(1);
            end
            tdpt_pkg::OP_NEXT_DIVISOR: begin
                // (d + 2)^2 = d^2 + 4d + 4
                r_sq <= r_sq + (SW'(r_d) << 2) + SW'(4);
                r_d  <= r_d + DW'(2);
            end
            tdpt_pkg::OP_CLR_PRIME: begin
                r_prime <= 1'b0;
            end
            tdpt_pkg::OP_SET_PRIME: begin
                r_prime <= 1'b1;
            end
            tdpt_pkg::OP_EMIT: begin
                o_number       <= 16'(r_n);
                o_within_range <= (r_n >= r_lower) && (r_n <= r_upper);
                o_prime_flag   <= r_prime;
            end
            default: begin
            end
        endcase
    end

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted candidate did not start the sequencer");

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without an item in progress");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe lasted more than one cycle");

    a_idle_after_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> !busy)
        else $error("sequencer not idle when the result is presented");

endmodule
